// ----- src/mer_pkg.sv -----
// shared types, widths and the control store of the midpoint ellipse rasterizer
// used by mer_datapath and midpoint_ellipse_rasterizer; no dependencies
package mer_pkg;

  // field widths
  localparam int CW  = 12;                 // center coordinate
  localparam int RW  = 11;                 // radius
  localparam int XW  = RW + 1;             // walk column, may reach the radius plus one
  localparam int SQW = 2 * RW;             // squared radius
  localparam int STW = SQW + XW + 1;       // slope terms
  localparam int MW  = 2 * (XW + 1);       // multiplier operand
  localparam int PW  = 2 * MW;             // multiplier product
  localparam int TW  = 2 * SQW;            // scratch register
  localparam int DW  = TW + 6;             // decision, two's complement
  localparam int PTW = CW + 2;             // output point, two's complement

  localparam int IN_TDW  = ((2 * CW + 2 * RW + 7) / 8) * 8;
  localparam int OUT_TDW = ((2 * PTW + 7) / 8) * 8;

  // opcodes on in_tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // control store
  localparam int PCW       = 5;
  localparam int ROM_DEPTH = 25;

  localparam logic [PCW-1:0] UA_RX2  = PCW'(0);   // start: rx*rx
  localparam logic [PCW-1:0] UA_RY2  = PCW'(1);   // start: ry*ry
  localparam logic [PCW-1:0] UA_AXRY = PCW'(2);   // start: rx2*ry
  localparam logic [PCW-1:0] UA_STY0 = PCW'(3);   // start: slope y
  localparam logic [PCW-1:0] UA_DEC0 = PCW'(4);   // start: decision, part one
  localparam logic [PCW-1:0] UA_DEC1 = PCW'(5);
  localparam logic [PCW-1:0] UA_DEC2 = PCW'(6);
  localparam logic [PCW-1:0] UA_S1X  = PCW'(7);   // region one step entry
  localparam logic [PCW-1:0] UA_S1Y  = PCW'(8);
  localparam logic [PCW-1:0] UA_S1DY = PCW'(9);
  localparam logic [PCW-1:0] UA_S1DA = PCW'(10);
  localparam logic [PCW-1:0] UA_S1DX = PCW'(11);
  localparam logic [PCW-1:0] UA_R2TX = PCW'(12);  // region change: rebuild decision
  localparam logic [PCW-1:0] UA_R2DA = PCW'(13);
  localparam logic [PCW-1:0] UA_R2PP = PCW'(14);
  localparam logic [PCW-1:0] UA_R2DB = PCW'(15);
  localparam logic [PCW-1:0] UA_R2TY = PCW'(16);
  localparam logic [PCW-1:0] UA_R2TM = PCW'(17);
  localparam logic [PCW-1:0] UA_R2DC = PCW'(18);
  localparam logic [PCW-1:0] UA_EMIT = PCW'(19);  // four points out
  localparam logic [PCW-1:0] UA_S2Y  = PCW'(20);  // region two step entry
  localparam logic [PCW-1:0] UA_S2X  = PCW'(21);
  localparam logic [PCW-1:0] UA_S2DX = PCW'(22);
  localparam logic [PCW-1:0] UA_S2DA = PCW'(23);
  localparam logic [PCW-1:0] UA_S2DY = PCW'(24);

  typedef enum logic [1:0] {A_ZERO, A_DEC, A_STX, A_STY} asel_t;

  typedef enum logic [3:0] {
    B_AY2_X2, B_AX2_X2, B_AY2_X4, B_AX2_X4,
    B_STX_X4, B_STY_X4, B_TMP_X2, B_TMP_X4, B_AX2
  } bsel_t;

  typedef enum logic [2:0] {M_RX, M_RY, M_AX2, M_AY2, M_TX, M_TYA, M_TMP} msel_t;

  typedef enum logic [2:0] {D_NONE, D_AX2, D_AY2, D_STX, D_STY, D_DEC, D_TMP} dest_t;

  typedef enum logic [2:0] {J_NEXT, J_ALWAYS, J_DEC_NEG, J_DEC_POS, J_STX_LT_STY} jcond_t;

  typedef enum logic {SQ_IDLE, SQ_RUN} seq_state_t;

  typedef struct packed {
    asel_t          a_sel;
    bsel_t          b_sel;
    logic           sub;
    msel_t          mul_a;
    msel_t          mul_b;
    logic           from_mul;
    dest_t          dest;
    logic           inc_x;
    logic           dec_y;
    logic           set_r2;
    logic           chk_end;
    logic           emit;
    logic           done;
    jcond_t         jcond;
    logic [PCW-1:0] target;
  } uword_t;

  typedef struct packed {
    logic          exec;
    logic          start;
    logic [RW-1:0] rx;
    logic [RW-1:0] ry;
  } dp_ctrl_t;

  typedef struct packed {
    logic          dec_neg;
    logic          dec_pos;
    logic          stx_lt_sty;
    logic          wy_zero;
    logic          in_region_two;
    logic          busy;
    logic [XW-1:0] walk_x;
    logic [RW-1:0] walk_y;
  } dp_status_t;

  localparam uword_t UW_NOP = '{
    a_sel: A_ZERO, b_sel: B_AX2, sub: 1'b0, mul_a: M_RX, mul_b: M_RX,
    from_mul: 1'b0, dest: D_NONE, inc_x: 1'b0, dec_y: 1'b0, set_r2: 1'b0,
    chk_end: 1'b0, emit: 1'b0, done: 1'b0, jcond: J_NEXT, target: '0
  };

  // the microprogram
  function automatic uword_t ucode(input logic [PCW-1:0] addr);
    uword_t w;
    w = UW_NOP;
    case (addr)
      UA_RX2: begin
        w.from_mul = 1'b1; w.mul_a = M_RX; w.mul_b = M_RX; w.dest = D_AX2;
      end
      UA_RY2: begin
        w.from_mul = 1'b1; w.mul_a = M_RY; w.mul_b = M_RY; w.dest = D_AY2;
      end
      UA_AXRY: begin
        w.from_mul = 1'b1; w.mul_a = M_AX2; w.mul_b = M_RY; w.dest = D_TMP;
      end
      UA_STY0: begin
        w.a_sel = A_ZERO; w.b_sel = B_TMP_X2; w.dest = D_STY;
      end
      UA_DEC0: begin
        w.a_sel = A_ZERO; w.b_sel = B_AY2_X4; w.dest = D_DEC;
      end
      UA_DEC1: begin
        w.a_sel = A_DEC; w.b_sel = B_AX2; w.dest = D_DEC;
      end
      UA_DEC2: begin
        w.a_sel = A_DEC; w.b_sel = B_TMP_X4; w.sub = 1'b1; w.dest = D_DEC; w.done = 1'b1;
      end
      UA_S1X: begin
        w.a_sel = A_STX; w.b_sel = B_AY2_X2; w.dest = D_STX; w.inc_x = 1'b1;
        w.jcond = J_DEC_NEG; w.target = UA_S1DA;
      end
      UA_S1Y: begin
        w.a_sel = A_STY; w.b_sel = B_AX2_X2; w.sub = 1'b1; w.dest = D_STY; w.dec_y = 1'b1;
      end
      UA_S1DY: begin
        w.a_sel = A_DEC; w.b_sel = B_STY_X4; w.sub = 1'b1; w.dest = D_DEC;
      end
      UA_S1DA: begin
        w.a_sel = A_DEC; w.b_sel = B_AY2_X4; w.dest = D_DEC;
      end
      UA_S1DX: begin
        w.a_sel = A_DEC; w.b_sel = B_STX_X4; w.dest = D_DEC;
        w.jcond = J_STX_LT_STY; w.target = UA_EMIT;
      end
      UA_R2TX: begin
        w.from_mul = 1'b1; w.mul_a = M_TX; w.mul_b = M_TX; w.dest = D_TMP; w.set_r2 = 1'b1;
      end
      UA_R2DA: begin
        w.from_mul = 1'b1; w.mul_a = M_AY2; w.mul_b = M_TMP; w.dest = D_DEC;
      end
      UA_R2PP: begin
        w.from_mul = 1'b1; w.mul_a = M_AX2; w.mul_b = M_AY2; w.dest = D_TMP;
      end
      UA_R2DB: begin
        w.a_sel = A_DEC; w.b_sel = B_TMP_X4; w.sub = 1'b1; w.dest = D_DEC;
      end
      UA_R2TY: begin
        w.from_mul = 1'b1; w.mul_a = M_TYA; w.mul_b = M_TYA; w.dest = D_TMP;
      end
      UA_R2TM: begin
        w.from_mul = 1'b1; w.mul_a = M_AX2; w.mul_b = M_TMP; w.dest = D_TMP;
      end
      UA_R2DC: begin
        w.a_sel = A_DEC; w.b_sel = B_TMP_X4; w.dest = D_DEC; w.chk_end = 1'b1;
      end
      UA_EMIT: begin
        w.emit = 1'b1;
      end
      UA_S2Y: begin
        w.a_sel = A_STY; w.b_sel = B_AX2_X2; w.sub = 1'b1; w.dest = D_STY; w.dec_y = 1'b1;
        w.jcond = J_DEC_POS; w.target = UA_S2DA;
      end
      UA_S2X: begin
        w.a_sel = A_STX; w.b_sel = B_AY2_X2; w.dest = D_STX; w.inc_x = 1'b1;
      end
      UA_S2DX: begin
        w.a_sel = A_DEC; w.b_sel = B_STX_X4; w.dest = D_DEC;
      end
      UA_S2DA: begin
        w.a_sel = A_DEC; w.b_sel = B_AX2_X4; w.dest = D_DEC;
      end
      UA_S2DY: begin
        w.a_sel = A_DEC; w.b_sel = B_STY_X4; w.sub = 1'b1; w.dest = D_DEC; w.chk_end = 1'b1;
        w.jcond = J_ALWAYS; w.target = UA_EMIT;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- src/mer_datapath.sv -----
// walk state, shared multiplier and adder of the ellipse rasterizer
// driven one control word per cycle by the sequencer while it runs and the output is not stalled; depends on mer_pkg
module mer_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  mer_pkg::uword_t     uw,
  input  mer_pkg::dp_ctrl_t   ctl,
  output mer_pkg::dp_status_t st
);

  logic [mer_pkg::RW-1:0]  rx_r, rx_nxt, ry_r, ry_nxt;
  logic [mer_pkg::XW-1:0]  wx_r, wx_nxt;
  logic [mer_pkg::RW-1:0]  wy_r, wy_nxt;
  logic [mer_pkg::SQW-1:0] ax2_r, ax2_nxt, ay2_r, ay2_nxt;
  logic [mer_pkg::STW-1:0] stx_r, stx_nxt, sty_r, sty_nxt;
  logic [mer_pkg::DW-1:0]  dec_r, dec_nxt;
  logic [mer_pkg::TW-1:0]  tmp_r, tmp_nxt;
  logic                    r2_r, r2_nxt, busy_r, busy_nxt;

  logic [mer_pkg::XW:0]    tx;
  logic [mer_pkg::RW-1:0]  tya;
  logic [mer_pkg::MW-1:0]  ma, mb;
  logic [mer_pkg::PW-1:0]  prod;
  logic [mer_pkg::DW-1:0]  opa, opb, alu, src;

  function automatic logic [mer_pkg::MW-1:0] mul_op(
    input mer_pkg::msel_t          sel,
    input logic [mer_pkg::RW-1:0]  rx,
    input logic [mer_pkg::RW-1:0]  ry,
    input logic [mer_pkg::SQW-1:0] ax2,
    input logic [mer_pkg::SQW-1:0] ay2,
    input logic [mer_pkg::XW:0]    tx_v,
    input logic [mer_pkg::RW-1:0]  tya_v,
    input logic [mer_pkg::MW-1:0]  tmp_lo
  );
    logic [mer_pkg::MW-1:0] v;
    case (sel)
      mer_pkg::M_RX:  v = mer_pkg::MW'(rx);
      mer_pkg::M_RY:  v = mer_pkg::MW'(ry);
      mer_pkg::M_AX2: v = mer_pkg::MW'(ax2);
      mer_pkg::M_AY2: v = mer_pkg::MW'(ay2);
      mer_pkg::M_TX:  v = mer_pkg::MW'(tx_v);
      mer_pkg::M_TYA: v = mer_pkg::MW'(tya_v);
      mer_pkg::M_TMP: v = tmp_lo;
      default:        v = '0;
    endcase
    return v;
  endfunction

  // 2x+1 and |y-1| for the region two start value
  assign tx  = {wx_r, 1'b1};
  assign tya = (wy_r == '0) ? mer_pkg::RW'(1) : wy_r - mer_pkg::RW'(1);

  assign ma   = mul_op(uw.mul_a, rx_r, ry_r, ax2_r, ay2_r, tx, tya, tmp_r[mer_pkg::MW-1:0]);
  assign mb   = mul_op(uw.mul_b, rx_r, ry_r, ax2_r, ay2_r, tx, tya, tmp_r[mer_pkg::MW-1:0]);
  assign prod = ma * mb;

  always_comb begin
    case (uw.a_sel)
      mer_pkg::A_ZERO: opa = '0;
      mer_pkg::A_DEC:  opa = dec_r;
      mer_pkg::A_STX:  opa = mer_pkg::DW'(stx_r);
      mer_pkg::A_STY:  opa = mer_pkg::DW'(sty_r);
      default:         opa = '0;
    endcase
    case (uw.b_sel)
      mer_pkg::B_AY2_X2: opb = mer_pkg::DW'(ay2_r) << 1;
      mer_pkg::B_AX2_X2: opb = mer_pkg::DW'(ax2_r) << 1;
      mer_pkg::B_AY2_X4: opb = mer_pkg::DW'(ay2_r) << 2;
      mer_pkg::B_AX2_X4: opb = mer_pkg::DW'(ax2_r) << 2;
      mer_pkg::B_STX_X4: opb = mer_pkg::DW'(stx_r) << 2;
      mer_pkg::B_STY_X4: opb = mer_pkg::DW'(sty_r) << 2;
      mer_pkg::B_TMP_X2: opb = mer_pkg::DW'(tmp_r) << 1;
      mer_pkg::B_TMP_X4: opb = mer_pkg::DW'(tmp_r) << 2;
      mer_pkg::B_AX2:    opb = mer_pkg::DW'(ax2_r);
      default:           opb = '0;
    endcase
    alu = uw.sub ? opa - opb : opa + opb;
    src = uw.from_mul ? prod[mer_pkg::DW-1:0] : alu;
  end

  always_comb begin
    rx_nxt   = rx_r;
    ry_nxt   = ry_r;
    wx_nxt   = wx_r;
    wy_nxt   = wy_r;
    ax2_nxt  = ax2_r;
    ay2_nxt  = ay2_r;
    stx_nxt  = stx_r;
    sty_nxt  = sty_r;
    dec_nxt  = dec_r;
    tmp_nxt  = tmp_r;
    r2_nxt   = r2_r;
    busy_nxt = busy_r;
    if (ctl.start) begin
      rx_nxt   = ctl.rx;
      ry_nxt   = ctl.ry;
      wx_nxt   = '0;
      wy_nxt   = ctl.ry;
      stx_nxt  = '0;
      r2_nxt   = 1'b0;
      busy_nxt = 1'b1;
    end else if (ctl.exec) begin
      case (uw.dest)
        mer_pkg::D_AX2: ax2_nxt = src[mer_pkg::SQW-1:0];
        mer_pkg::D_AY2: ay2_nxt = src[mer_pkg::SQW-1:0];
        mer_pkg::D_STX: stx_nxt = src[mer_pkg::STW-1:0];
        mer_pkg::D_STY: sty_nxt = src[mer_pkg::STW-1:0];
        mer_pkg::D_DEC: dec_nxt = src;
        mer_pkg::D_TMP: tmp_nxt = src[mer_pkg::TW-1:0];
        default: ;
      endcase
      if (uw.inc_x) wx_nxt = wx_r + mer_pkg::XW'(1);
      if (uw.dec_y) wy_nxt = wy_r - mer_pkg::RW'(1);
      if (uw.set_r2) r2_nxt = 1'b1;
      if (uw.chk_end && (wy_r == '0)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r2_r   <= 1'b0;
      busy_r <= 1'b0;
    end else begin
      r2_r   <= r2_nxt;
      busy_r <= busy_nxt;
    end
    rx_r  <= rx_nxt;
    ry_r  <= ry_nxt;
    wx_r  <= wx_nxt;
    wy_r  <= wy_nxt;
    ax2_r <= ax2_nxt;
    ay2_r <= ay2_nxt;
    stx_r <= stx_nxt;
    sty_r <= sty_nxt;
    dec_r <= dec_nxt;
    tmp_r <= tmp_nxt;
  end

  assign st.dec_neg       = dec_r[mer_pkg::DW-1];
  assign st.dec_pos       = !dec_r[mer_pkg::DW-1] && (dec_r != '0);
  assign st.stx_lt_sty    = stx_r < sty_r;
  assign st.wy_zero       = wy_r == '0;
  assign st.in_region_two = r2_r;
  assign st.busy          = busy_r;
  assign st.walk_x        = wx_r;
  assign st.walk_y        = wy_r;

endmodule

// ----- src/midpoint_ellipse_rasterizer.sv -----
// top level of the midpoint ellipse rasterizer: stream ports, microcode sequencer
// and point output register; depends on mer_pkg and mer_datapath
//
// A start transfer (in_tuser low) latches the center, forces each radius to at
// least 1 and runs the setup program; it gives no output. Each step
// transfer (in_tuser high) runs one iteration of the two-region midpoint walk
// and then sends the four mirror points of the position held before the
// iteration, in the order (+x,+y), (-x,+y), (+x,-y), (-x,-y), one per cycle
// while the sink is ready, the fourth with out_tlast. out_tuser is set on all
// four points of the step that ends the walk. A step while no walk is active
// is taken and dropped. The decision variable is kept exactly, scaled by four.
// Everything runs from a 25-word control store, one word per cycle unless the
// output stalls, over a single multiplier and a single adder: a step takes 3
// or 5 words in either region, plus 7 words on the step that moves into region
// two, then sends its points. The next transfer is taken as soon as the last
// point sits in the output register.
module midpoint_ellipse_rasterizer (
  input  logic                        clk,
  input  logic                        rst_n,
  // center_x, center_y, radius_x, radius_y from bit 0 up, zero padded
  input  logic [mer_pkg::IN_TDW-1:0]  in_tdata,
  // opcode
  input  logic                        in_tuser,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // point_x, point_y from bit 0 up, zero padded
  output logic [mer_pkg::OUT_TDW-1:0] out_tdata,
  // final_step
  output logic                        out_tuser,
  // last_of_step
  output logic                        out_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready
);

  localparam int CW  = mer_pkg::CW;
  localparam int RW  = mer_pkg::RW;
  localparam int PTW = mer_pkg::PTW;

  mer_pkg::seq_state_t     state_r, state_nxt;
  logic [mer_pkg::PCW-1:0] pc_r, pc_nxt;
  logic [1:0]              pt_r, pt_nxt;       // point index within a step
  logic                    fin_r, fin_nxt;     // this step ends the walk
  logic [mer_pkg::XW-1:0]  px_r, px_nxt;       // walk position before the step
  logic [RW-1:0]           py_r, py_nxt;
  logic [CW-1:0]           hcx_r, hcx_nxt, hcy_r, hcy_nxt;

  logic [PTW-1:0]          opx_r, opx_nxt, opy_r, opy_nxt;
  logic                    olast_r, olast_nxt, ofin_r, ofin_nxt;
  logic                    ovalid_r, ovalid_nxt;

  mer_pkg::uword_t         uw;
  mer_pkg::dp_ctrl_t       ctl;
  mer_pkg::dp_status_t     st;

  logic                    in_xfer, load_pt, jump;
  logic [CW-1:0]           f_cx, f_cy;
  logic [RW-1:0]           f_rx, f_ry;
  logic [PTW-1:0]          cxe, cye, xe, ye;

  // payload fields
  assign f_cx = in_tdata[CW-1:0];
  assign f_cy = in_tdata[2*CW-1:CW];
  assign f_rx = in_tdata[2*CW+RW-1:2*CW];
  assign f_ry = in_tdata[2*CW+2*RW-1:2*CW+RW];

  assign uw      = mer_pkg::ucode(pc_r);
  assign in_xfer = in_tvalid && in_tready;

  // mirror points of the held position
  assign cxe = PTW'(hcx_r);
  assign cye = PTW'(hcy_r);
  assign xe  = PTW'(px_r);
  assign ye  = PTW'(py_r);

  always_comb begin
    case (uw.jcond)
      mer_pkg::J_NEXT:       jump = 1'b0;
      mer_pkg::J_ALWAYS:     jump = 1'b1;
      mer_pkg::J_DEC_NEG:    jump = st.dec_neg;
      mer_pkg::J_DEC_POS:    jump = st.dec_pos;
      mer_pkg::J_STX_LT_STY: jump = st.stx_lt_sty;
      default:               jump = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    pc_nxt     = pc_r;
    pt_nxt     = pt_r;
    fin_nxt    = fin_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    hcx_nxt    = hcx_r;
    hcy_nxt    = hcy_r;
    opx_nxt    = opx_r;
    opy_nxt    = opy_r;
    olast_nxt  = olast_r;
    ofin_nxt   = ofin_r;
    ovalid_nxt = ovalid_r && !out_tready;
    in_tready  = 1'b0;
    load_pt    = 1'b0;
    ctl.exec   = 1'b0;
    ctl.start  = 1'b0;
    // radius below one is taken as one
    ctl.rx     = (f_rx == '0) ? RW'(1) : f_rx;
    ctl.ry     = (f_ry == '0) ? RW'(1) : f_ry;

    case (state_r)
      mer_pkg::SQ_IDLE: begin
        in_tready = 1'b1;
        if (in_xfer) begin
          if (in_tuser == mer_pkg::OP_START) begin
            ctl.start = 1'b1;
            hcx_nxt   = f_cx;
            hcy_nxt   = f_cy;
            pc_nxt    = mer_pkg::UA_RX2;
            state_nxt = mer_pkg::SQ_RUN;
          end else if (st.busy) begin
            px_nxt    = st.walk_x;
            py_nxt    = st.walk_y;
            fin_nxt   = 1'b0;
            pt_nxt    = '0;
            pc_nxt    = st.in_region_two ? mer_pkg::UA_S2Y : mer_pkg::UA_S1X;
            state_nxt = mer_pkg::SQ_RUN;
          end
        end
      end
      mer_pkg::SQ_RUN: begin
        ctl.exec = 1'b1;
        if (uw.chk_end && st.wy_zero) fin_nxt = 1'b1;
        if (uw.emit) begin
          // hold on this word until all four points are loaded
          if (!ovalid_r || out_tready) begin
            load_pt    = 1'b1;
            opx_nxt    = pt_r[0] ? cxe - xe : cxe + xe;
            opy_nxt    = pt_r[1] ? cye - ye : cye + ye;
            olast_nxt  = &pt_r;
            ofin_nxt   = fin_r;
            ovalid_nxt = 1'b1;
            pt_nxt     = pt_r + 2'd1;
            if (&pt_r) state_nxt = mer_pkg::SQ_IDLE;
          end
        end else if (uw.done) begin
          state_nxt = mer_pkg::SQ_IDLE;
        end else if (jump) begin
          pc_nxt = uw.target;
        end else begin
          pc_nxt = pc_r + mer_pkg::PCW'(1);
        end
      end
      default: begin
        state_nxt = mer_pkg::SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mer_pkg::SQ_IDLE;
      pc_r     <= '0;
      pt_r     <= '0;
      fin_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pc_r     <= pc_nxt;
      pt_r     <= pt_nxt;
      fin_r    <= fin_nxt;
      ovalid_r <= ovalid_nxt;
    end
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    hcx_r   <= hcx_nxt;
    hcy_r   <= hcy_nxt;
    opx_r   <= opx_nxt;
    opy_r   <= opy_nxt;
    olast_r <= olast_nxt;
    ofin_r  <= ofin_nxt;
  end

  mer_datapath u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .uw    (uw),
    .ctl   (ctl),
    .st    (st)
  );

  assign out_tdata  = mer_pkg::OUT_TDW'({opy_r, opx_r});
  assign out_tuser  = ofin_r;
  assign out_tlast  = olast_r;
  assign out_tvalid = ovalid_r;

  // the control store is never left
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mer_pkg::SQ_RUN) |-> (pc_r < mer_pkg::PCW'(mer_pkg::ROM_DEPTH)))
    else $error("sequencer address outside the control store");

  // the walk row never steps below zero
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mer_pkg::SQ_RUN && uw.dec_y) |-> !st.wy_zero)
    else $error("walk row decremented at zero");

  // a final step only goes out once the walk is closed
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load_pt && fin_r) |-> !st.busy)
    else $error("final step emitted while walk still active");

  // the fourth point hands control back
  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (load_pt && (&pt_r)) |=> (state_r == mer_pkg::SQ_IDLE))
    else $error("sequencer still running after last point");

endmodule
